// ===== src/smr_pkg.sv =====
// Shared types and constants for the servo motion ramp block.
// Holds the request and status payload structs and the controller/datapath link.
// No dependencies.
package smr_pkg;

   // Field widths of the command and status payloads.
   localparam int US_W     = 12;
   localparam int TIME_W   = 14;
   localparam int ANGLE_W  = 16;
   localparam int SCALE_W  = 16;
   localparam int MAXANG_W = 9;
   localparam int BIAS_W   = 12;
   localparam int CHAN_W   = 3;
   localparam int REQ_W    = 3;
   localparam int FRAC_OUT_W = 16;
   localparam int CSR_DATA_W = 16;

   // Request codes.
   localparam logic [REQ_W-1:0] REQ_MOVE  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_STOP  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_BIAS  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_TICK  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_ANGLE = 3'd4;

   // Configuration register indexes.
   localparam logic CSR_MAX_ANGLE   = 1'b0;
   localparam logic CSR_ANGLE_SCALE = 1'b1;

   localparam logic [MAXANG_W-1:0] MAX_ANGLE_RESET   = 9'd180;
   localparam logic [SCALE_W-1:0]  ANGLE_SCALE_RESET = 16'd64881;

   // Pulse width limits in whole microseconds.
   localparam logic [US_W-1:0] TARGET_LOW   = 12'd510;
   localparam logic [US_W-1:0] TARGET_HIGH  = 12'd2490;
   localparam logic [US_W-1:0] SNAP_LOW     = 12'd500;
   localparam logic [US_W-1:0] ANGLE_BASE   = 12'd500;
   localparam logic [US_W-1:0] POS_RESET_US = 12'd1500;
   localparam int              STEP_RESET_US = 20;

   // Move durations in milliseconds.
   localparam logic [TIME_W-1:0] TIME_LIMIT = 14'd10000;
   localparam logic [TIME_W-1:0] TIME_CLIP  = 14'd9999;
   localparam logic [TIME_W-1:0] TIME_MIN   = 14'd20;
   localparam logic [TIME_W-1:0] ANGLE_TIME = 14'd1000;

   // Angle times scale carries 8 + 16 fraction bits.
   localparam int ANGLE_DEN_SHIFT = 24;

   typedef struct packed {
      logic [REQ_W-1:0]         req_type;
      logic [CHAN_W-1:0]        channel;
      logic                     all_channels;
      logic [US_W-1:0]          target_us;
      logic [TIME_W-1:0]        time_ms;
      logic signed [BIAS_W-1:0] bias_us;
      logic [ANGLE_W-1:0]       angle;
   } smr_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]        out_channel;
      logic [US_W-1:0]          position_us;
      logic [FRAC_OUT_W-1:0]    position_frac;
      logic [US_W-1:0]          aim_us;
      logic                     moving;
      logic signed [BIAS_W-1:0] bias_out;
   } smr_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic halt_all;
      logic halt;
      logic set_bias;
      logic move_load;
      logic move_jump;
      logic move_diff;
      logic step_div;
      logic step_write;
      logic tick_prep;
      logic tick_apply;
      logic ang_clamp;
      logic ang_mul;
      logic ang_div;
      logic ang_target;
      logic report;
   } smr_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [REQ_W-1:0] req_type;
      logic             chan_ok;
      logic             all_stop;
      logic             step_zero;
      logic             target_zero;
      logic             time_short;
      logic             div_done;
   } smr_stat_type;

endpackage

// ===== src/servo_motion_ramp_core.sv =====
// Top level of the servo motion ramp block.
// Depends on smr_pkg, smr_control, smr_datapath and smr_divider.
//
// Usage:
//   A command (move, stop, set bias, tick, set angle) is transferred at a rising
//   clock edge with start high and busy low. busy stays high until the command's
//   single status result has been produced; rsp_valid then strobes for one cycle
//   with rsp_data, and the receiver must take it in that cycle.
//   The next command may be transferred during the strobe cycle.
//   Stop, bias, unknown and out-of-range commands and a tick on a stopped
//   channel go from decode straight to the report step; any other tick and a
//   move that stops or jumps pass through their own tick or move step first.
//   Ramped moves and angles wait for the shared restoring divider; an angle runs it twice.
//   The csr port writes max_angle (index 0) and angle_scale (index 1);
//   write them only while busy is low.
//   Reset (synchronous, active high) puts every channel at 1500 us with a step
//   of 20 us, zero bias, and restores the register defaults at once.
module servo_motion_ramp_core
   import smr_pkg::*;
#(
   parameter int NUM_CHANNELS = 8,
   parameter int FRAC_BITS    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  smr_req_type           req_data,
   output logic                  rsp_valid,
   output smr_rsp_type           rsp_data,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   smr_cmd_type  cmd;
   smr_stat_type stat;

   smr_control u_control (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   smr_datapath #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .FRAC_BITS    (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/smr_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Used by the servo ramp datapath for the step and angle divisions; no dependencies.
module smr_divider #(
   parameter int DIVIDEND_W = 33,
   parameter int DIVISOR_W  = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [DIVIDEND_W-1:0] shift_ff, shift_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    trial_sub;

   always_comb begin
      trial      = {rem_ff, shift_ff[DIVIDEND_W-1]};
      trial_sub  = trial - {1'b0, divisor_ff};
      count_in   = count_ff;
      run_in     = run_ff;
      done_in    = 1'b0;
      shift_in   = shift_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         shift_in   = dividend;
         rem_in     = '0;
         divisor_in = divisor;
         count_in   = CNT_W'(DIVIDEND_W);
         run_in     = 1'b1;
      end else if (run_ff) begin
         // The dividend shifts out at the top while quotient bits enter at the bottom.
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in   = trial_sub[DIVISOR_W-1:0];
            shift_in = {shift_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in   = trial[DIVISOR_W-1:0];
            shift_in = {shift_ff[DIVIDEND_W-2:0], 1'b0};
         end
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         run_ff   <= run_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff   <= shift_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = shift_ff;

endmodule

// ===== src/smr_datapath.sv =====
// Datapath of the servo ramp: per-channel state, move, tick and angle arithmetic.
// Depends on smr_pkg and smr_divider; driven by commands from smr_control.
module smr_datapath
   import smr_pkg::*;
#(
   parameter int NUM_CHANNELS = 8,
   parameter int FRAC_BITS    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  smr_req_type           req_data,
   input  smr_cmd_type           cmd,
   output smr_stat_type          stat,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output smr_rsp_type           rsp_data
);

   localparam int POS_W  = US_W + FRAC_BITS;
   localparam int STEP_W = POS_W + 1;
   localparam int LIM_W  = STEP_W + 1;
   localparam int DIVD_W = POS_W + 5;
   localparam int NUM_W  = 2 * ANGLE_W + 11;
   localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int SMALL_RAW  = ((1 << FRAC_BITS) + 500) / 1000;
   localparam int SMALL_STEP = (SMALL_RAW < 1) ? 1 : SMALL_RAW;

   localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};
   localparam logic [POS_W-1:0] POS_RESET = {POS_RESET_US, {FRAC_BITS{1'b0}}};
   localparam logic signed [STEP_W-1:0] STEP_RESET =
      STEP_W'(STEP_RESET_US * (1 << FRAC_BITS));
   localparam logic signed [STEP_W-1:0] STEP_SMALL = STEP_W'(SMALL_STEP);

   function automatic logic [US_W-1:0] clamp_target(input logic [US_W-1:0] t);
      logic [US_W-1:0] r;
      if (t == '0) begin
         r = '0;
      end else if (t > TARGET_HIGH) begin
         r = TARGET_HIGH;
      end else if (t < TARGET_LOW) begin
         r = TARGET_LOW;
      end else begin
         r = t;
      end
      return r;
   endfunction

   // Per-channel state.
   logic [POS_W-1:0]         aim_ff  [NUM_CHANNELS];
   logic [POS_W-1:0]         cur_ff  [NUM_CHANNELS];
   logic signed [STEP_W-1:0] step_ff [NUM_CHANNELS];
   logic signed [BIAS_W-1:0] bias_ff [NUM_CHANNELS];

   logic [MAXANG_W-1:0] max_angle_ff;
   logic [SCALE_W-1:0]  angle_scale_ff;

   // Request and working registers.
   smr_req_type              req_ff;
   logic [CH_W-1:0]          ch_ff;
   logic [CHAN_W-1:0]        out_ch_ff;
   logic                     chan_ok_ff;
   logic                     all_stop_ff;
   logic [US_W-1:0]          mv_target_ff;
   logic [TIME_W-1:0]        mv_time_ff;
   logic signed [POS_W:0]    diff_ff;
   logic [POS_W-1:0]         snap_ff;
   logic [POS_W-1:0]         dist_ff;
   logic [LIM_W-1:0]         lim_ff;
   logic signed [LIM_W-1:0]  next_ff;
   logic [ANGLE_W-1:0]       ang_c_ff;
   logic [2*ANGLE_W-1:0]     prod_ff;
   smr_rsp_type              rsp_ff;

   logic                     load_all_stop;
   logic                     load_in_range;
   logic [POS_W-1:0]         aim_rd;
   logic [POS_W-1:0]         cur_rd;
   logic signed [STEP_W-1:0] step_rd;
   logic signed [BIAS_W-1:0] bias_rd;
   logic [US_W-1:0]          snap_raw;
   logic [US_W-1:0]          snap_us;
   logic [POS_W-1:0]         snap_pos;
   logic signed [POS_W:0]    tick_diff;
   logic [POS_W-1:0]         tick_dist;
   logic [STEP_W-1:0]        step_mag;
   logic signed [LIM_W-1:0]  tick_next;
   logic [POS_W-1:0]         tick_sat;
   logic [POS_W-1:0]         tgt_pos;
   logic signed [POS_W:0]    move_diff;
   logic [POS_W-1:0]         diff_mag;
   logic [STEP_W-1:0]        quo_step;
   logic signed [STEP_W-1:0] step_new;
   logic [MAXANG_W-1:0]      full;
   logic [ANGLE_W:0]         full_sh;
   logic [ANGLE_W-1:0]       ang_c;
   logic [NUM_W-1:0]         prod_ext;
   logic [NUM_W-1:0]         ang_num;
   logic [DIVD_W-1:0]        div_dividend;
   logic [TIME_W-1:0]        div_divisor;
   logic                     div_done;
   logic [DIVD_W-1:0]        div_quo;
   logic [FRAC_BITS+FRAC_OUT_W-1:0] frac_wide;

   always_comb begin
      load_all_stop = (req_data.req_type == REQ_STOP) && req_data.all_channels;
      load_in_range = int'(req_data.channel) < NUM_CHANNELS;

      aim_rd  = aim_ff[ch_ff];
      cur_rd  = cur_ff[ch_ff];
      step_rd = step_ff[ch_ff];
      bias_rd = bias_ff[ch_ff];

      // Tick: snap point from the integer part of the aim.
      snap_raw = aim_rd[POS_W-1:FRAC_BITS];
      if (snap_raw > TARGET_HIGH) begin
         snap_us = TARGET_HIGH;
      end else if (snap_raw < SNAP_LOW) begin
         snap_us = SNAP_LOW;
      end else begin
         snap_us = snap_raw;
      end
      snap_pos  = {snap_us, {FRAC_BITS{1'b0}}};
      tick_diff = $signed({1'b0, snap_pos}) - $signed({1'b0, cur_rd});
      tick_dist = tick_diff[POS_W] ? POS_W'(-tick_diff) : tick_diff[POS_W-1:0];
      step_mag  = step_rd[STEP_W-1] ? STEP_W'(-step_rd) : step_rd;
      tick_next = $signed({2'b00, cur_rd}) + $signed({step_rd[STEP_W-1], step_rd});

      if (next_ff[LIM_W-1]) begin
         tick_sat = '0;
      end else if (next_ff[POS_W]) begin
         tick_sat = POS_MAX;
      end else begin
         tick_sat = next_ff[POS_W-1:0];
      end

      // Move: signed distance to the target, then its magnitude times 20.
      tgt_pos   = {mv_target_ff, {FRAC_BITS{1'b0}}};
      move_diff = $signed({1'b0, tgt_pos}) - $signed({1'b0, cur_rd});
      diff_mag  = diff_ff[POS_W] ? POS_W'(-diff_ff) : diff_ff[POS_W-1:0];
      quo_step  = div_quo[STEP_W-1:0];
      step_new  = diff_ff[POS_W] ? -$signed(quo_step) : $signed(quo_step);

      // Angle: clamp to full scale, then scale by 2000 as shift and subtract.
      full     = (max_angle_ff == '0) ? MAXANG_W'(1) : max_angle_ff;
      full_sh  = {full, 8'h00};
      ang_c    = ({1'b0, req_ff.angle} > full_sh) ? full_sh[ANGLE_W-1:0] : req_ff.angle;
      prod_ext = NUM_W'(prod_ff);
      ang_num  = (prod_ext << 11) - (prod_ext << 5) - (prod_ext << 4);

      if (cmd.ang_div) begin
         div_dividend = DIVD_W'(ang_num[NUM_W-1:ANGLE_DEN_SHIFT]);
         div_divisor  = TIME_W'(full);
      end else begin
         div_dividend = (DIVD_W'(diff_mag) << 4) + (DIVD_W'(diff_mag) << 2);
         div_divisor  = mv_time_ff;
      end

      frac_wide = {cur_rd[FRAC_BITS-1:0], {FRAC_OUT_W{1'b0}}};
   end

   smr_divider #(
      .DIVIDEND_W (DIVD_W),
      .DIVISOR_W  (TIME_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.step_div | cmd.ang_div),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Channel state.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            aim_ff[i]  <= POS_RESET;
            cur_ff[i]  <= POS_RESET;
            step_ff[i] <= STEP_RESET;
            bias_ff[i] <= '0;
         end
      end else if (cmd.halt_all) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            step_ff[i] <= '0;
            aim_ff[i]  <= cur_ff[i];
         end
      end else if (cmd.halt) begin
         step_ff[ch_ff] <= '0;
         aim_ff[ch_ff]  <= cur_rd;
      end else if (cmd.set_bias) begin
         bias_ff[ch_ff] <= req_ff.bias_us;
         step_ff[ch_ff] <= STEP_SMALL;
      end else if (cmd.move_jump) begin
         aim_ff[ch_ff]  <= tgt_pos;
         cur_ff[ch_ff]  <= tgt_pos;
         step_ff[ch_ff] <= '0;
      end else if (cmd.move_diff) begin
         aim_ff[ch_ff] <= tgt_pos;
      end else if (cmd.step_write) begin
         step_ff[ch_ff] <= step_new;
      end else if (cmd.tick_apply) begin
         if (LIM_W'(dist_ff) <= lim_ff) begin
            cur_ff[ch_ff]  <= snap_ff;
            step_ff[ch_ff] <= '0;
         end else begin
            cur_ff[ch_ff] <= tick_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_angle_ff   <= MAX_ANGLE_RESET;
         angle_scale_ff <= ANGLE_SCALE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_ANGLE: begin
               max_angle_ff <= csr_wdata[MAXANG_W-1:0];
            end
            CSR_ANGLE_SCALE: begin
               angle_scale_ff <= csr_wdata[SCALE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Working registers; but for the result register, their contents matter only inside one command.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff      <= req_data;
         all_stop_ff <= load_all_stop;
         chan_ok_ff  <= load_all_stop || load_in_range;
         ch_ff       <= load_all_stop ? '0 : CH_W'(req_data.channel);
         out_ch_ff   <= load_all_stop ? '0 : req_data.channel;
      end
      if (cmd.move_load) begin
         mv_target_ff <= clamp_target(req_ff.target_us);
         mv_time_ff   <= (req_ff.time_ms > TIME_LIMIT) ? TIME_CLIP : req_ff.time_ms;
      end else if (cmd.ang_target) begin
         mv_target_ff <= clamp_target(ANGLE_BASE + {1'b0, div_quo[US_W-2:0]});
         mv_time_ff   <= ANGLE_TIME;
      end
      if (cmd.move_diff) begin
         diff_ff <= move_diff;
      end
      if (cmd.tick_prep) begin
         snap_ff <= snap_pos;
         dist_ff <= tick_dist;
         lim_ff  <= {step_mag, 1'b0};
         next_ff <= tick_next;
      end
      if (cmd.ang_clamp) begin
         ang_c_ff <= ang_c;
      end
      if (cmd.ang_mul) begin
         prod_ff <= (2*ANGLE_W)'(ang_c_ff) * (2*ANGLE_W)'(angle_scale_ff);
      end
      if (cmd.report) begin
         rsp_ff.out_channel <= out_ch_ff;
         if (chan_ok_ff) begin
            rsp_ff.position_us   <= cur_rd[POS_W-1:FRAC_BITS];
            rsp_ff.position_frac <= frac_wide[FRAC_BITS+FRAC_OUT_W-1:FRAC_BITS];
            rsp_ff.aim_us        <= aim_rd[POS_W-1:FRAC_BITS];
            rsp_ff.moving        <= (step_rd != '0);
            rsp_ff.bias_out      <= bias_rd;
         end else begin
            rsp_ff.position_us   <= '0;
            rsp_ff.position_frac <= '0;
            rsp_ff.aim_us        <= '0;
            rsp_ff.moving        <= 1'b0;
            rsp_ff.bias_out      <= '0;
         end
      end
   end

   always_comb begin
      stat.req_type    = req_ff.req_type;
      stat.chan_ok     = chan_ok_ff;
      stat.all_stop    = all_stop_ff;
      stat.step_zero   = (step_rd == '0);
      stat.target_zero = (mv_target_ff == '0);
      stat.time_short  = (mv_time_ff < TIME_MIN);
      stat.div_done    = div_done;
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== src/smr_control.sv =====
// Command sequencer of the servo ramp: decodes a request into datapath steps.
// Depends on smr_pkg; controls smr_datapath through smr_cmd_type and smr_stat_type.
module smr_control
   import smr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  smr_stat_type stat,
   output smr_cmd_type  cmd,
   output logic         busy,
   output logic         rsp_valid
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_MOVE,
      S_STEP_DIV,
      S_STEP_WAIT,
      S_TICK,
      S_ANG_MUL,
      S_ANG_DIV,
      S_ANG_WAIT,
      S_REPORT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_REPORT;
            if (stat.all_stop) begin
               cmd.halt_all = 1'b1;
            end else if (stat.chan_ok) begin
               case (stat.req_type)
                  REQ_MOVE: begin
                     cmd.move_load = 1'b1;
                     state_in      = S_MOVE;
                  end
                  REQ_STOP: begin
                     cmd.halt = 1'b1;
                  end
                  REQ_BIAS: begin
                     cmd.set_bias = 1'b1;
                  end
                  REQ_TICK: begin
                     if (!stat.step_zero) begin
                        cmd.tick_prep = 1'b1;
                        state_in      = S_TICK;
                     end
                  end
                  REQ_ANGLE: begin
                     cmd.ang_clamp = 1'b1;
                     state_in      = S_ANG_MUL;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MOVE: begin
            // A zero target stops the channel; a very short move jumps there.
            if (stat.target_zero) begin
               cmd.halt = 1'b1;
               state_in = S_REPORT;
            end else if (stat.time_short) begin
               cmd.move_jump = 1'b1;
               state_in      = S_REPORT;
            end else begin
               cmd.move_diff = 1'b1;
               state_in      = S_STEP_DIV;
            end
         end
         S_STEP_DIV: begin
            cmd.step_div = 1'b1;
            state_in     = S_STEP_WAIT;
         end
         S_STEP_WAIT: begin
            if (stat.div_done) begin
               cmd.step_write = 1'b1;
               state_in       = S_REPORT;
            end
         end
         S_TICK: begin
            cmd.tick_apply = 1'b1;
            state_in       = S_REPORT;
         end
         S_ANG_MUL: begin
            cmd.ang_mul = 1'b1;
            state_in    = S_ANG_DIV;
         end
         S_ANG_DIV: begin
            cmd.ang_div = 1'b1;
            state_in    = S_ANG_WAIT;
         end
         S_ANG_WAIT: begin
            if (stat.div_done) begin
               cmd.ang_target = 1'b1;
               state_in       = S_MOVE;
            end
         end
         S_REPORT: begin
            cmd.report = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= (state_in != S_IDLE);
         rsp_valid_ff <= (state_ff == S_REPORT);
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

   // A result strobe follows only the report step.
   a_rsp_after_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == S_REPORT))
      else $error("result strobe without a report step");

   // Back-to-back commands still leave a gap between result strobes.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");

   // An accepted command makes the block busy on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> busy_ff)
      else $error("accepted command did not raise busy");

   // The divider finishes only while the sequencer waits for it.
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      stat.div_done |-> (state_ff == S_STEP_WAIT || state_ff == S_ANG_WAIT))
      else $error("divider finished outside a wait step");

endmodule
